/* sv/hpap_pkg.sv */
package hpap_pkg;

    localparam logic [7:0] SYNC_BYTE      = 8'hAA;
    localparam logic [7:0] EXT_BYTE       = 8'h55;
    localparam logic [7:0] ATTENTION_CODE = 8'h04;
    localparam logic [7:0] MAX_LENGTH     = 8'd169;
    localparam logic [7:0] LEVEL_FLOOR    = 8'd50;
    localparam logic [7:0] LEVEL_STEP     = 8'd5;
    localparam logic [3:0] LEVEL_TOP      = 4'd9;
    localparam logic [5:0] CHAR_ZERO      = 6'd48;

    typedef enum logic [2:0] {
        FR_SYNC1,
        FR_SYNC2,
        FR_LENGTH,
        FR_PAYLOAD,
        FR_CHECKSUM,
        FR_DRAIN_RD,
        FR_DRAIN_LOAD
    } frame_state_t;

    typedef enum logic [1:0] {
        ROW_CODE,
        ROW_LENGTH,
        ROW_DATA
    } row_state_t;

    typedef struct packed {
        logic start_frame;
        logic take_payload;
        logic drain_start;
        logic drain_read;
        logic drain_load;
    } hpap_cmd_t;

    typedef struct packed {
        logic byte_is_sync;
        logic length_bad;
        logic length_zero;
        logic payload_last;
        logic checksum_ok;
        logic has_values;
        logic drain_last;
        logic out_free;
    } hpap_status_t;

    // Maps a raw attention byte to '0' + min(9, (a - 50) / 5), or '0' when a <= 50.
    function automatic logic [5:0] level_char(input logic [7:0] a);
        logic [7:0] d;
        logic [3:0] step;
        d    = a - LEVEL_FLOOR;
        step = '0;
        for (int i = 1; i <= 9; i++) begin
            if (d >= 8'(i * 5)) begin
                step = 4'(i);
            end
        end
        if (a <= LEVEL_FLOOR) begin
            step = '0;
        end else if (d >= LEVEL_STEP * 8'(LEVEL_TOP)) begin
            step = LEVEL_TOP;
        end
        return CHAR_ZERO + {2'b00, step};
    endfunction

endpackage

/* sv/hpap_ram.sv */
module hpap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/hpap_ctrl.sv */
module hpap_ctrl
    import hpap_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  hpap_status_t st,
    output hpap_cmd_t    cmd
);

    frame_state_t state_reg;
    frame_state_t state_next;
    logic         in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_SYNC1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg != FR_DRAIN_RD) && (state_reg != FR_DRAIN_LOAD);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            FR_SYNC1:
            begin
                if (in_fire && st.byte_is_sync)
                begin
                    state_next = FR_SYNC2;
                end
            end
            FR_SYNC2:
            begin
                if (in_fire)
                begin
                    state_next = st.byte_is_sync ? FR_LENGTH : FR_SYNC1;
                end
            end
            FR_LENGTH:
            begin
                // Extra sync bytes are skipped while waiting for the length.
                if (in_fire && !st.byte_is_sync)
                begin
                    if (st.length_bad)
                    begin
                        state_next = FR_SYNC1;
                    end
                    else
                    begin
                        cmd.start_frame = 1'b1;
                        state_next = st.length_zero ? FR_CHECKSUM : FR_PAYLOAD;
                    end
                end
            end
            FR_PAYLOAD:
            begin
                if (in_fire)
                begin
                    cmd.take_payload = 1'b1;
                    if (st.payload_last)
                    begin
                        state_next = FR_CHECKSUM;
                    end
                end
            end
            FR_CHECKSUM:
            begin
                if (in_fire)
                begin
                    if (st.checksum_ok && st.has_values)
                    begin
                        cmd.drain_start = 1'b1;
                        state_next = FR_DRAIN_RD;
                    end
                    else
                    begin
                        state_next = FR_SYNC1;
                    end
                end
            end
            FR_DRAIN_RD:
            begin
                cmd.drain_read = 1'b1;
                state_next = FR_DRAIN_LOAD;
            end
            FR_DRAIN_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.drain_load = 1'b1;
                    state_next = st.drain_last ? FR_SYNC1 : FR_DRAIN_RD;
                end
            end
            default:
            begin
                state_next = FR_SYNC1;
            end
        endcase
    end

endmodule

/* sv/hpap_datapath.sv */
module hpap_datapath
    import hpap_pkg::*;
#(
    parameter int PENDING_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   rx_byte,
    input  hpap_cmd_t    cmd,
    output hpap_status_t st,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   attention_raw,
    output logic [5:0]   attention_char,
    output logic         last_in_packet
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1) > 0 ? $clog2(PENDING_DEPTH + 1) : 1;

    logic [7:0]    expected_length_reg;
    logic [7:0]    bytes_received_reg;
    logic [7:0]    running_sum_reg;
    row_state_t    row_phase_reg, row_phase_next;
    logic [7:0]    row_code_reg, row_code_next;
    logic [7:0]    row_left_reg, row_left_next;
    logic          extended_reg, extended_next;
    logic [CW-1:0] pend_count_reg;
    logic [AW-1:0] drain_idx_reg;
    logic          out_valid_reg;
    logic [7:0]    raw_reg;
    logic [5:0]    char_reg;
    logic          last_reg;

    logic          store_en;
    logic [7:0]    rd_data;
    logic [CW-1:0] drain_idx_inc;

    // Row parser: one payload byte per call.
    always_comb
    begin
        row_phase_next = row_phase_reg;
        row_code_next  = row_code_reg;
        row_left_next  = row_left_reg;
        extended_next  = extended_reg;
        store_en       = 1'b0;
        case (row_phase_reg)
            ROW_CODE:
            begin
                if (rx_byte == EXT_BYTE)
                begin
                    extended_next = 1'b1;
                end
                else
                begin
                    row_code_next = rx_byte;
                    if (rx_byte[7])
                    begin
                        row_phase_next = ROW_LENGTH;
                    end
                    else
                    begin
                        row_left_next  = 8'd1;
                        row_phase_next = ROW_DATA;
                    end
                end
            end
            ROW_LENGTH:
            begin
                row_left_next = rx_byte;
                if (rx_byte == 8'd0)
                begin
                    row_phase_next = ROW_CODE;
                    extended_next  = 1'b0;
                end
                else
                begin
                    row_phase_next = ROW_DATA;
                end
            end
            default:
            begin
                store_en = (row_code_reg == ATTENTION_CODE) && !extended_reg &&
                           (pend_count_reg < CW'(PENDING_DEPTH));
                row_left_next = row_left_reg - 8'd1;
                if (row_left_reg == 8'd1)
                begin
                    row_phase_next = ROW_CODE;
                    extended_next  = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_length_reg <= '0;
            bytes_received_reg  <= '0;
            running_sum_reg     <= '0;
            row_phase_reg       <= ROW_CODE;
            row_code_reg        <= '0;
            row_left_reg        <= '0;
            extended_reg        <= 1'b0;
            pend_count_reg      <= '0;
            drain_idx_reg       <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.start_frame)
            begin
                expected_length_reg <= rx_byte;
                bytes_received_reg  <= '0;
                running_sum_reg     <= '0;
                row_phase_reg       <= ROW_CODE;
                row_code_reg        <= '0;
                row_left_reg        <= '0;
                extended_reg        <= 1'b0;
                pend_count_reg      <= '0;
            end
            else if (cmd.take_payload)
            begin
                bytes_received_reg <= bytes_received_reg + 8'd1;
                running_sum_reg    <= running_sum_reg + rx_byte;
                row_phase_reg      <= row_phase_next;
                row_code_reg       <= row_code_next;
                row_left_reg       <= row_left_next;
                extended_reg       <= extended_next;
                if (store_en)
                begin
                    pend_count_reg <= pend_count_reg + CW'(1);
                end
            end

            if (cmd.drain_start)
            begin
                drain_idx_reg <= '0;
            end
            else if (cmd.drain_load)
            begin
                drain_idx_reg <= drain_idx_reg + AW'(1);
            end

            if (cmd.drain_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_load)
        begin
            raw_reg  <= rd_data;
            char_reg <= level_char(rd_data);
            last_reg <= st.drain_last;
        end
    end

    hpap_ram #(
        .WIDTH (8),
        .DEPTH (PENDING_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.take_payload && store_en),
        .wr_addr (pend_count_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (cmd.drain_read),
        .rd_addr (drain_idx_reg),
        .rd_data (rd_data)
    );

    assign drain_idx_inc = CW'(drain_idx_reg) + CW'(1);

    assign st.byte_is_sync = (rx_byte == SYNC_BYTE);
    assign st.length_bad   = (rx_byte > MAX_LENGTH);
    assign st.length_zero  = (rx_byte == 8'd0);
    assign st.payload_last = ({1'b0, bytes_received_reg} + 9'd1) >= {1'b0, expected_length_reg};
    assign st.checksum_ok  = (rx_byte == ~running_sum_reg);
    assign st.has_values   = (pend_count_reg != '0);
    assign st.drain_last   = (drain_idx_inc == pend_count_reg);
    assign st.out_free     = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign attention_raw  = raw_reg;
    assign attention_char = char_reg;
    assign last_in_packet = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_count_reg <= CW'(PENDING_DEPTH))
        else $error("stored value count exceeds store depth");

    a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_read |-> (CW'(drain_idx_reg) < pend_count_reg))
        else $error("drain reads beyond the stored values");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

/* sv/headset_packet_attention_parser_core.sv */
// Attention packet parser for a headset serial stream.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per
// transaction. The parser hunts for two sync bytes, reads the length, sums
// and parses the payload rows, and stores the value byte of each plain
// attention row (up to PENDING_DEPTH per packet) in a small RAM.
// Output channel (out_valid/out_ready) carries attention_raw, attention_char
// and last_in_packet, one transaction per stored value, after a packet whose
// checksum byte matches. A bad checksum emits nothing.
// Throughput: one input byte per cycle while framing and parsing. On a good
// checksum with stored values the input stalls while the store is drained:
// each value takes a RAM read, then a load of the output register.
// A stalled receiver holds the output register; draining waits for it, but
// once draining is done new bytes are taken even while the last result waits.
// Reset clears the framing state and output valid; the parser then hunts for
// the first sync byte. Store contents are not cleared, only the count.
module headset_packet_attention_parser_core
    import hpap_pkg::*;
#(
    parameter int PENDING_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] attention_raw,
    output logic [5:0] attention_char,
    output logic       last_in_packet
);

    hpap_cmd_t    cmd;
    hpap_status_t st;

    hpap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    hpap_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .attention_raw  (attention_raw),
        .attention_char (attention_char),
        .last_in_packet (last_in_packet)
    );

endmodule
